### sv/psl_pkg.sv
// Package for the priority sorted list: field widths, command and status codes,
// sequencer states and the compare request type.
// No dependencies.
package psl_pkg;

    localparam int ID_W        = 16;
    localparam int PRIO_W      = 16;
    localparam int KEY_W       = 16;
    localparam int PAYLOAD_IN_W = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS,
        S_INS_HEAD,
        S_REM,
        S_DONE
    } t_state;

    typedef enum logic [0:0] {
        CMP_GE = 1'b0,
        CMP_EQ = 1'b1
    } t_cmp_mode;

    typedef struct packed {
        t_cmp_mode        mode;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
    } t_cmp_req;

endpackage

### sv/psl_mem.sv
// Entry store of the priority sorted list: one write port, one registered read port.
// Depends on nothing.
module psl_mem #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/psl_cmp.sv
// Shared key compare unit: priority greater-or-equal, or id equality.
// Depends on psl_pkg.
module psl_cmp
    import psl_pkg::*;
(
    input  t_cmp_req i_req,
    output logic     o_hit
);

    always_comb begin
        case (i_req.mode)
            CMP_GE:  o_hit = (i_req.key_a >= i_req.key_b);
            CMP_EQ:  o_hit = (i_req.key_a == i_req.key_b);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

### sv/psl_ctrl.sv
// Sequencer of the priority sorted list: walks the entry store one slot per cycle
// for insert (from the tail) and remove (from the head), using the shared compare.
// Depends on psl_pkg.
module psl_ctrl
    import psl_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int AW            = $clog2(DEPTH),
    parameter int CW            = $clog2(DEPTH + 1),
    parameter int EW            = ID_W + PRIO_W + PAYLOAD_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cmd                    i_cmd,
    input  logic [ID_W-1:0]         i_id,
    input  logic [PRIO_W-1:0]       i_prio,
    input  logic [PAYLOAD_IN_W-1:0] i_payload,
    input  logic                    i_out_free,
    output logic                    o_done,
    output t_status                 o_status,
    output logic [CW-1:0]           o_count,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic [EW-1:0]           o_wdata,
    output logic [AW-1:0]           o_raddr,
    input  logic [EW-1:0]           i_rdata,
    output t_cmp_req                o_cmp,
    input  logic                    i_hit
);

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    t_status                  r_status, n_status;
    logic [ID_W-1:0]          r_id, n_id;
    logic [PRIO_W-1:0]        r_prio, n_prio;
    logic [PAYLOAD_WIDTH-1:0] r_payload, n_payload;
    logic [AW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_found, n_found;
    logic [EW-1:0]            new_entry;
    logic [ID_W-1:0]          rd_id;
    logic [PRIO_W-1:0]        rd_prio;
    logic                     last_slot;

    assign new_entry = {r_payload, r_prio, r_id};
    assign rd_id     = i_rdata[ID_W-1:0];
    assign rd_prio   = i_rdata[ID_W +: PRIO_W];
    assign last_slot = (r_idx == AW'(r_count - 1'b1));

    always_comb begin
        o_cmp.mode  = (r_cmd == CMD_INSERT) ? CMP_GE : CMP_EQ;
        o_cmp.key_a = (r_cmd == CMD_INSERT) ? rd_prio : rd_id;
        o_cmp.key_b = (r_cmd == CMD_INSERT) ? r_prio : r_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_id      <= n_id;
        r_prio    <= n_prio;
        r_payload <= n_payload;
        r_idx     <= n_idx;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_status  = r_status;
        n_id      = r_id;
        n_prio    = r_prio;
        n_payload = r_payload;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        o_ready   = 1'b0;
        o_done    = 1'b0;
        o_we      = 1'b0;
        o_waddr   = '0;
        o_wdata   = new_entry;
        o_raddr   = r_idx;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd     = i_cmd;
                    n_id      = i_id;
                    n_prio    = i_prio;
                    n_payload = PAYLOAD_WIDTH'(i_payload);
                    n_status  = ST_OK;
                    n_found   = 1'b0;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_count == '0) begin
                        o_we    = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                        n_state = S_DONE;
                    end else begin
                        o_raddr = AW'(r_count - 1'b1);
                        n_idx   = AW'(r_count - 1'b1);
                        n_state = S_INS;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        o_raddr = '0;
                        n_idx   = '0;
                        n_state = S_REM;
                    end
                end
            end
            S_INS: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_idx + 1'b1);
                if (i_hit) begin
                    n_count = CW'(r_count + 1'b1);
                    n_state = S_DONE;
                end else begin
                    o_wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        o_raddr = AW'(r_idx - 1'b1);
                        n_idx   = AW'(r_idx - 1'b1);
                    end
                end
            end
            S_INS_HEAD: begin
                o_we    = 1'b1;
                n_count = CW'(r_count + 1'b1);
                n_state = S_DONE;
            end
            S_REM: begin
                if (r_found) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_idx - 1'b1);
                    o_wdata = i_rdata;
                end else if (i_hit) begin
                    n_found = 1'b1;
                end
                if (last_slot) begin
                    if (r_found || i_hit) begin
                        n_count = CW'(r_count - 1'b1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    o_raddr = AW'(r_idx + 1'b1);
                    n_idx   = AW'(r_idx + 1'b1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status = r_status;
    assign o_count  = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_status == ST_FULL)) |-> (r_count == CW'(DEPTH)))
        else $error("full status with free slots");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("store write outside a walk");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("count changed while idle");

endmodule

### sv/priority_sorted_list_top.sv
// Priority sorted list: an insert into a list that is neither empty nor full, and a remove
// from a non-empty list, walk the entry store one slot per cycle. One item at a time.
// Result waits in an output register so the next item is accepted while it is held.
// Reset (i_rst_n low, synchronous) empties the list; store contents are not cleared.
module priority_sorted_list_top
    import psl_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // entry_id[15:0], priority_req[31:16], payload[63:32]
    input  logic [0:0]  s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // count[4:0], empty_res[5], zero[7:6]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ID_W + PRIO_W + PAYLOAD_WIDTH;

    logic                   out_free;
    logic                   done;
    t_status                status;
    logic [CW-1:0]          count;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [EW-1:0]          wdata;
    logic [EW-1:0]          rdata;
    t_cmp_req               cmp_req;
    logic                   hit;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                   r_out_empty;

    assign out_free = !r_out_valid || m_axis_tready;

    psl_ctrl #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .i_id       (s_axis_tdata[15:0]),
        .i_prio     (s_axis_tdata[31:16]),
        .i_payload  (s_axis_tdata[63:32]),
        .i_out_free (out_free),
        .o_done     (done),
        .o_status   (status),
        .o_count    (count),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_cmp      (cmp_req),
        .i_hit      (hit)
    );

    psl_mem #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    psl_cmp u_cmp (
        .i_req (cmp_req),
        .o_hit (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out_status <= status;
            r_out_count  <= COUNT_OUT_W'(count);
            r_out_empty  <= (count == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_empty, r_out_count};
    assign m_axis_tuser  = r_out_status;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_out_valid || m_axis_tready))
        else $error("result register overwritten");

    a_idle_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !done)
        else $error("result right after accept");

endmodule

### tb/sv/testbench.sv
// Testbench for priority_sorted_list_top: sends insert and remove commands on the input
// stream and checks every status, count and empty flag against a list model or scripted reply.
// Depends on psl_pkg and priority_sorted_list_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psl_pkg::*;

    localparam int LIST_DEPTH       = 16;
    localparam int RANDOM_ITEMS     = 500;
    localparam int SEGMENT_ITEMS    = 50;
    localparam int SINK_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 2 * (LIST_DEPTH + 4);
    localparam int CYCLE_LIMIT      = 400000;

    typedef struct packed {
        t_status    status;
        logic [4:0] count;
        logic       empty;
    } list_reply_t;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] id;
        logic [15:0] prio;
        logic [31:0] payload;
        bit          typed;
        list_reply_t reply;
    } scripted_cmd_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // entry_id[15:0], priority_req[31:16], payload[63:32]
    logic [0:0]  s_axis_tuser;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // count[4:0], empty_res[5], zero[7:6]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    logic [ID_W-1:0]   held_id      [LIST_DEPTH];
    logic [PRIO_W-1:0] held_prio    [LIST_DEPTH];
    logic [31:0]       held_payload [LIST_DEPTH];
    int                held_count    = 0;

    list_reply_t queued_replies[$];
    int          bad_replies   = 0;
    int          hold_requests = 0;
    bit          sink_busy     = 1'b0;
    int          cycle_count   = 0;

    priority_sorted_list_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic list_reply_t predict_reply(t_cmd cmd, logic [ID_W-1:0] id,
            logic [PRIO_W-1:0] prio, logic [31:0] payload);
        list_reply_t r;
        int pos;
        int i;
        r.status = ST_OK;
        pos = 0;
        if (cmd == CMD_INSERT) begin
            if (held_count >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                while (pos < held_count && held_prio[pos] >= prio) pos++;
                for (i = held_count; i > pos; i--) begin
                    held_id[i]      = held_id[i-1];
                    held_prio[i]    = held_prio[i-1];
                    held_payload[i] = held_payload[i-1];
                end
                held_id[pos]      = id;
                held_prio[pos]    = prio;
                held_payload[pos] = payload;
                held_count++;
            end
        end else begin
            while (pos < held_count && held_id[pos] != id) pos++;
            if (pos >= held_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (i = pos; i + 1 < held_count; i++) begin
                    held_id[i]      = held_id[i+1];
                    held_prio[i]    = held_prio[i+1];
                    held_payload[i] = held_payload[i+1];
                end
                held_count--;
            end
        end
        r.count = 5'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic idle_sender(int cycles);
        if (cycles > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic send_command(t_cmd cmd, logic [15:0] id, logic [15:0] prio,
            logic [31:0] payload, bit typed, list_reply_t typed_reply);
        list_reply_t predicted;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {payload, prio, id};
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_reply(cmd, id, prio, payload);
        queued_replies.push_back(typed ? typed_reply : predicted);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("priority_sorted_list_top verification failed");
        $finish;
    end

    initial begin : sink
        int hold_served;
        int k;
        hold_served = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                m_axis_tready = 1'b0;
                for (k = 0; k < SINK_HOLD_CYCLES; k++) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else if (sink_busy && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat (idle_len() + 1) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        list_reply_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (queued_replies.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("unexpected reply: status %0d count %0d empty %0d",
                             m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[5]);
            end else begin
                want = queued_replies.pop_front();
                if (m_axis_tuser != want.status || m_axis_tdata[4:0] != want.count ||
                        m_axis_tdata[5] != want.empty) begin
                    bad_replies++;
                    if (bad_replies <= 10)
                        $display("mismatch: want status %0d count %0d empty %0d, got %0d %0d %0d",
                                 want.status, want.count, want.empty,
                                 m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[5]);
                end
            end
        end
    end

    initial begin : stimulus
        scripted_cmd_t script[$];
        scripted_cmd_t row;
        list_reply_t   none;
        int            seg;
        int            n;
        int            k;
        int            mode;
        int            insert_pct;
        bit            gap_on;
        t_cmd          cmd;
        logic [15:0]   id;
        logic [15:0]   prio;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        none = '{ST_OK, 5'd0, 1'b0};
        script.push_back('{CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
                           '{ST_NOT_FOUND, 5'd0, 1'b1}});
        script.push_back('{CMD_INSERT, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1,
                           '{ST_OK, 5'd1, 1'b0}});
        script.push_back('{CMD_INSERT, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                           '{ST_OK, 5'd2, 1'b0}});
        script.push_back('{CMD_INSERT, 16'h0005, 16'h8000, 32'hA5A5_A5A5, 1'b0, none});
        script.push_back('{CMD_INSERT, 16'h0005, 16'h8000, 32'h5A5A_5A5A, 1'b0, none});
        script.push_back('{CMD_REMOVE, 16'h0005, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, none});
        script.push_back('{CMD_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, none});
        script.push_back('{CMD_REMOVE, 16'h1234, 16'h0000, 32'h0000_0000, 1'b0, none});
        for (k = 0; k < 14; k++)
            script.push_back('{CMD_INSERT, 16'h0100 + 16'(k), 16'(k % 4) * 16'h4000,
                               $urandom(), 1'b0, none});
        script.push_back('{CMD_INSERT, 16'hBEEF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                           '{ST_FULL, 5'd16, 1'b0}});
        script.push_back('{CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, none});
        script.push_back('{CMD_REMOVE, 16'h010D, 16'h0000, 32'h0000_0000, 1'b0, none});

        wait (i_rst_n);
        @(negedge i_clk);

        foreach (script[k]) begin
            row = script[k];
            idle_sender(idle_len());
            send_command(row.cmd, row.id, row.prio, row.payload, row.typed, row.reply);
        end

        for (seg = 0; seg < RANDOM_ITEMS / SEGMENT_ITEMS; seg++) begin
            mode = seg % 3;
            insert_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
            gap_on = ($urandom_range(0, 2) != 0);
            sink_busy = ($urandom_range(0, 2) != 0);
            if (seg == 2) begin
                gap_on = 1'b0;
                hold_requests++;
            end
            if (seg == 5 || $urandom_range(0, 3) == 0) begin
                idle_sender(1);
                while (queued_replies.size() != 0) @(negedge i_clk);
            end
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                if (gap_on) idle_sender(idle_len());
                cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                if (cmd == CMD_REMOVE && held_count > 0 && $urandom_range(0, 9) < 7)
                    id = held_id[$urandom_range(0, held_count - 1)];
                else if ($urandom_range(0, 9) < 7)
                    id = 16'($urandom_range(0, 23));
                else
                    id = 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 3))
                    0: prio = 16'($urandom_range(0, 3));
                    1: prio = 16'($urandom_range(0, 3)) * 16'h5555;
                    default: prio = 16'($urandom_range(0, 65535));
                endcase
                send_command(cmd, id, prio, $urandom(), 1'b0, none);
            end
        end

        idle_sender(1);
        while (queued_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_replies == 0)
            $display("priority_sorted_list_top verification clean");
        else
            $display("priority_sorted_list_top verification failed");
        $finish;
    end

endmodule

### priority_sorted_list_top.f
sv/psl_pkg.sv
sv/psl_mem.sv
sv/psl_cmp.sv
sv/psl_ctrl.sv
sv/priority_sorted_list_top.sv
tb/sv/testbench.sv
